[hdl/pbdt_pkg.sv]
// Shared constants and types for the drop-tail packet buffer.
`timescale 1ns / 1ps
`default_nettype none
package pbdt_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W = 32;
  localparam int DUR_W = 16;
  localparam int CFG_W = 7;
  localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;
  localparam logic [CFG_W-1:0] BUF_SIZE_RST = CFG_W'(64);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_RETIRE = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic decide;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_ok;
  } dp_status_t;

endpackage
`default_nettype wire

[hdl/pbdt_ctrl.sv]
// Controller state machine that sequences accept, retirement and decision.
`timescale 1ns / 1ps
`default_nettype none
module pbdt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire pbdt_pkg::dp_status_t status,
  output pbdt_pkg::ctrl_cmd_t       cmd,
  output logic                      out_valid
);

  pbdt_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      pbdt_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = pbdt_pkg::ST_RETIRE;
        end
      end
      pbdt_pkg::ST_RETIRE: begin
        if (status.pop_ok) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.decide    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pbdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pbdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbdt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != pbdt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[hdl/pbdt_dp.sv]
// Datapath with the finish-time ring, pointers, capacity register and result registers.
`timescale 1ns / 1ps
`default_nettype none
module pbdt_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire pbdt_pkg::ctrl_cmd_t                cmd,
  output pbdt_pkg::dp_status_t                    status,
  input  wire logic [pbdt_pkg::TIME_W-1:0]        in_arrival_time,
  input  wire logic [pbdt_pkg::DUR_W-1:0]         in_duration,
  input  wire logic                               cfg_valid,
  input  wire logic [pbdt_pkg::CFG_W-1:0]         cfg_data,
  output logic                                    out_dropped,
  output logic [pbdt_pkg::TIME_W-1:0]             out_start_time
);

  logic [pbdt_pkg::TIME_W-1:0] ring [pbdt_pkg::QUEUE_DEPTH];
  logic [pbdt_pkg::TIME_W-1:0] rd_data_r;

  logic [pbdt_pkg::TIME_W-1:0] arrival_r;
  logic [pbdt_pkg::DUR_W-1:0]  duration_r;
  logic [pbdt_pkg::IDX_W-1:0]  head_r, head_nxt;
  logic [pbdt_pkg::IDX_W-1:0]  tail_r, tail_nxt;
  logic [pbdt_pkg::OCC_W-1:0]  occ_r, occ_nxt;
  logic [pbdt_pkg::TIME_W-1:0] last_finish_r, last_finish_nxt;
  logic [pbdt_pkg::CFG_W-1:0]  buf_size_r;
  logic                        dropped_r;
  logic [pbdt_pkg::TIME_W-1:0] start_time_r;

  logic [pbdt_pkg::CMP_W-1:0]  cap;
  logic                        full;
  logic [pbdt_pkg::TIME_W-1:0] start_val;
  logic [pbdt_pkg::TIME_W:0]   sum;
  logic [pbdt_pkg::TIME_W-1:0] finish_val;
  logic                        push;

  always_comb begin
    if (buf_size_r == '0) begin
      cap = pbdt_pkg::CMP_W'(1);
    end else if (pbdt_pkg::CMP_W'(buf_size_r) > pbdt_pkg::CMP_W'(pbdt_pkg::QUEUE_DEPTH)) begin
      cap = pbdt_pkg::CMP_W'(pbdt_pkg::QUEUE_DEPTH);
    end else begin
      cap = pbdt_pkg::CMP_W'(buf_size_r);
    end
  end

  assign full          = (pbdt_pkg::CMP_W'(occ_r) >= cap);
  assign status.pop_ok = (occ_r != '0) && (rd_data_r <= arrival_r);
  assign start_val     = (last_finish_r > arrival_r) ? last_finish_r : arrival_r;
  assign sum           = {1'b0, start_val} + (pbdt_pkg::TIME_W + 1)'(duration_r);
  assign finish_val    = sum[pbdt_pkg::TIME_W] ? '1 : sum[pbdt_pkg::TIME_W-1:0];
  assign push          = cmd.decide && !full;

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    occ_nxt         = occ_r;
    last_finish_nxt = last_finish_r;
    if (cmd.pop) begin
      head_nxt = (head_r == pbdt_pkg::IDX_W'(pbdt_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 head_r + pbdt_pkg::IDX_W'(1);
      occ_nxt  = occ_r - pbdt_pkg::OCC_W'(1);
    end
    if (push) begin
      tail_nxt = (tail_r == pbdt_pkg::IDX_W'(pbdt_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 tail_r + pbdt_pkg::IDX_W'(1);
      occ_nxt         = occ_r + pbdt_pkg::OCC_W'(1);
      last_finish_nxt = finish_val;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ring[tail_r] <= finish_val;
    end
    rd_data_r <= ring[head_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      occ_r         <= '0;
      last_finish_r <= '0;
      buf_size_r    <= pbdt_pkg::BUF_SIZE_RST;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      occ_r         <= occ_nxt;
      last_finish_r <= last_finish_nxt;
      if (cfg_valid) begin
        buf_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arrival_r  <= in_arrival_time;
      duration_r <= in_duration;
    end
    if (cmd.decide) begin
      dropped_r    <= full;
      start_time_r <= full ? '0 : start_val;
    end
  end

  assign out_dropped    = dropped_r;
  assign out_start_time = start_time_r;

endmodule
`default_nettype wire

[hdl/packet_buffer_drop_tail_sim.sv]
// Top level of the drop-tail packet buffer in front of a single server.
`timescale 1ns / 1ps
`default_nettype none
// A packet is taken when start is high and busy is low. The block then retires
// buffered packets whose finish time is at or before the arrival, one per cycle
// through the single read port of the finish-time ring. It decides in the first
// cycle that finds nothing more to retire. busy stays high through the retiring
// and the deciding, and each buffered packet retires only once. The result
// appears on the out_ ports for exactly one cycle, marked by out_valid, in the
// first cycle that busy is low again. The receiver cannot stall it and must
// capture it then. The next item can be taken in that same cycle. The user must
// write the capacity through cfg_data only while the block is idle; the block
// does not enforce this itself and accepts every write.
module packet_buffer_drop_tail_sim (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [pbdt_pkg::TIME_W-1:0]  in_arrival_time,
  input  wire logic [pbdt_pkg::DUR_W-1:0]   in_duration,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pbdt_pkg::CFG_W-1:0]   cfg_data,
  output logic                              out_valid,
  output logic                              out_dropped,
  output logic [pbdt_pkg::TIME_W-1:0]       out_start_time
);

  pbdt_pkg::ctrl_cmd_t  cmd;
  pbdt_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  pbdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .status    (status),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  pbdt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_arrival_time (in_arrival_time),
    .in_duration     (in_duration),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_dropped     (out_dropped),
    .out_start_time  (out_start_time)
  );

endmodule
`default_nettype wire

[hdl/pbdt_checker.sv]
// Port-level assertions for the drop-tail packet buffer and their bind.
`timescale 1ns / 1ps
`default_nettype none
module pbdt_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic                        out_dropped,
  input wire logic [pbdt_pkg::TIME_W-1:0] out_start_time
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("Accepted item did not make the block busy.");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result shown while the block is busy.");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe lasted more than one cycle.");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> (out_start_time == '0))
    else $error("Dropped item reports a nonzero start time.");

endmodule

bind packet_buffer_drop_tail_sim pbdt_checker u_pbdt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_dropped    (out_dropped),
  .out_start_time (out_start_time)
);
`default_nettype wire

[tb/tb_packet_buffer_drop_tail_sim.sv]
// Self-checking testbench for the drop-tail packet buffer: randomized packets and capacity phases.
`timescale 1ns / 1ps
module tb_packet_buffer_drop_tail_sim;

  typedef struct {
    bit                          is_cfg;
    logic [pbdt_pkg::CFG_W-1:0]  cap;
    logic [pbdt_pkg::TIME_W-1:0] arrival;
    logic [pbdt_pkg::DUR_W-1:0]  dur;
    int unsigned                 gap;
  } arrival_t;

  typedef struct {
    logic                        dropped;
    logic [pbdt_pkg::TIME_W-1:0] start_time;
  } sched_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [pbdt_pkg::TIME_W-1:0] in_arrival_time = '0;
  logic [pbdt_pkg::DUR_W-1:0] in_duration = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pbdt_pkg::CFG_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_dropped;
  logic [pbdt_pkg::TIME_W-1:0] out_start_time;

  arrival_t arrival_q[$];
  sched_t expected_sched_q[$];
  int pkts_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int unsigned idle_left = 0;

  // Scoreboard copy of the buffer state.
  logic [pbdt_pkg::TIME_W-1:0] finish_ring [pbdt_pkg::QUEUE_DEPTH];
  logic [pbdt_pkg::IDX_W-1:0] ring_head = '0;
  logic [pbdt_pkg::IDX_W-1:0] ring_tail = '0;
  logic [pbdt_pkg::OCC_W-1:0] ring_fill = '0;
  logic [pbdt_pkg::TIME_W-1:0] last_finish = '0;
  logic [pbdt_pkg::CFG_W-1:0] buffer_cap = pbdt_pkg::BUF_SIZE_RST;

  logic [pbdt_pkg::CFG_W-1:0] phase_cap [10] = '{64, 1, 0, 127, 2, 8, 33, 63, 65, 16};

  packet_buffer_drop_tail_sim u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_arrival_time(in_arrival_time),
    .in_duration    (in_duration),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_dropped    (out_dropped),
    .out_start_time (out_start_time)
  );

  always #6 clk = ~clk;

  function automatic logic [pbdt_pkg::TIME_W-1:0] later_by(
      input logic [pbdt_pkg::TIME_W-1:0] t,
      input logic [pbdt_pkg::TIME_W-1:0] d);
    logic [pbdt_pkg::TIME_W:0] s;
    s = {1'b0, t} + (pbdt_pkg::TIME_W + 1)'(d);
    return s[pbdt_pkg::TIME_W] ? '1 : s[pbdt_pkg::TIME_W-1:0];
  endfunction

  function automatic void schedule_packet(input logic [pbdt_pkg::TIME_W-1:0] arr,
                                          input logic [pbdt_pkg::DUR_W-1:0] dur,
                                          output sched_t res);
    logic [pbdt_pkg::CFG_W-1:0] cap;
    cap = buffer_cap;
    if (cap == '0) begin
      cap = pbdt_pkg::CFG_W'(1);
    end else if (cap > pbdt_pkg::CFG_W'(pbdt_pkg::QUEUE_DEPTH)) begin
      cap = pbdt_pkg::CFG_W'(pbdt_pkg::QUEUE_DEPTH);
    end
    while (ring_fill != 0 && finish_ring[ring_head] <= arr) begin
      ring_head = ring_head + 1'b1;
      ring_fill = ring_fill - 1'b1;
    end
    if (ring_fill >= cap) begin
      res.dropped = 1'b1;
      res.start_time = '0;
    end else begin
      res.dropped = 1'b0;
      res.start_time = (last_finish > arr) ? last_finish : arr;
      last_finish = later_by(res.start_time, pbdt_pkg::TIME_W'(dur));
      finish_ring[ring_tail] = last_finish;
      ring_tail = ring_tail + 1'b1;
      ring_fill = ring_fill + 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_packet(input logic [pbdt_pkg::TIME_W-1:0] arr,
                                     input logic [pbdt_pkg::DUR_W-1:0] dur, input bit calm);
    arrival_t item;
    item = '{1'b0, '0, arr, dur, calm ? 0 : pick_gap()};
    arrival_q.insert(arrival_q.size(), item);
  endfunction

  function automatic void add_cap(input logic [pbdt_pkg::CFG_W-1:0] cap);
    arrival_t item;
    item = '{1'b1, cap, '0, '0, pick_gap()};
    arrival_q.insert(arrival_q.size(), item);
  endfunction

  always @(posedge clk) begin : driver
    arrival_t nxt;
    sched_t res;
    logic take_pkt;
    logic take_cfg;
    take_pkt = start && !busy;
    take_cfg = cfg_valid && cfg_ready;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (take_pkt) begin
        schedule_packet(in_arrival_time, in_duration, res);
        expected_sched_q.insert(expected_sched_q.size(), res);
        pkts_sent++;
      end
      if (take_cfg) begin
        buffer_cap = cfg_data;
      end
      if ((start && !take_pkt) || (cfg_valid && !take_cfg)) begin
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (arrival_q.size() != 0 && (!arrival_q[0].is_cfg ||
                   (pkts_sent == results_seen && !busy))) begin
        nxt = arrival_q.pop_front();
        idle_left = nxt.gap;
        if (nxt.is_cfg) begin
          start <= 1'b0;
          cfg_valid <= 1'b1;
          cfg_data <= nxt.cap;
        end else begin
          start <= 1'b1;
          cfg_valid <= 1'b0;
          in_arrival_time <= nxt.arrival;
          in_duration <= nxt.dur;
        end
      end else begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    sched_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_sched_q.size() == 0) begin
        report_mismatch("result with no packet pending");
      end else begin
        want = expected_sched_q.pop_front();
        if (out_dropped !== want.dropped) begin
          report_mismatch($sformatf("result %0d: dropped %b, expected %b",
                                    results_seen, out_dropped, want.dropped));
        end
        if (out_start_time !== want.start_time) begin
          report_mismatch($sformatf("result %0d: start_time %0d, expected %0d",
                                    results_seen, out_start_time, want.start_time));
        end
      end
    end
  end

  initial begin : stimulus
    logic [pbdt_pkg::TIME_W-1:0] now;
    logic [pbdt_pkg::TIME_W-1:0] base;
    logic [pbdt_pkg::TIME_W-1:0] arr;
    logic [pbdt_pkg::DUR_W-1:0] dur;
    int unsigned dur_max;
    int unsigned step_max;
    int unsigned load;
    int unsigned r;
    bit calm;

    // Directed part: empty buffer, equal finish and arrival, out-of-order
    // arrival, capacity lowered below occupancy, out-of-range capacities.
    add_packet(0, 0, 0);
    add_packet(0, 0, 0);
    add_packet(5, 16'hFFFF, 0);
    add_packet(6, 10, 1);
    add_packet(3, 4, 1);
    add_packet(65540, 1, 0);
    add_cap(1);
    add_packet(65541, 7, 0);
    add_packet(65550, 2, 1);
    add_packet(65555, 3, 0);
    add_packet(65556, 1, 0);
    add_cap(0);
    add_packet(65556, 0, 1);
    add_packet(65558, 0, 0);
    add_packet(65558, 5, 0);
    add_cap(2);
    add_packet(65559, 100, 0);
    add_packet(65560, 1, 1);
    add_cap(127);
    for (int i = 0; i < 5; i++) begin
      add_packet(65600, 16'hFFFF, 0);
    end
    now = 65600;

    // Random phases, each with its own capacity, load and time base.
    for (int p = 0; p < 10; p++) begin
      add_cap(phase_cap[p]);
      base = p * 32'h1800_0000 + $urandom_range(0, 32'h00FF_FFFF);
      if (base > now) begin
        now = base;
      end
      calm = (p % 3 == 1);
      dur_max = $urandom_range(1, 400);
      load = (p == 0) ? 1 : $urandom_range(1, 12);
      step_max = dur_max * load / 8;
      for (int i = 0; i < 76; i++) begin
        r = $urandom_range(0, 99);
        if (r < 4 && now > 1000) begin
          arr = now - $urandom_range(1, 1000);
        end else begin
          now = later_by(now, $urandom_range(0, step_max));
          arr = now;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
          dur = pbdt_pkg::DUR_W'($urandom_range(0, 16'hFFFF));
        end else if (r < 8) begin
          dur = '0;
        end else begin
          dur = pbdt_pkg::DUR_W'($urandom_range(0, dur_max));
        end
        add_packet(arr, dur, calm);
      end
    end

    // Top of the time range, where finish times saturate.
    add_cap(64);
    now = 32'hFFFE_0000 + $urandom_range(0, 32'h0000_FFFF);
    for (int i = 0; i < 40; i++) begin
      now = later_by(now, $urandom_range(0, 4000));
      add_packet(now, pbdt_pkg::DUR_W'($urandom_range(0, 16'hFFFF)), 0);
    end
    add_packet(32'hFFFF_FFFF, 16'hFFFF, 0);
    add_packet(32'hFFFF_FFFF, 16'hFFFF, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(posedge clk);
    end while (arrival_q.size() != 0 || start || cfg_valid || pkts_sent != results_seen);
    repeat (80) @(posedge clk);
    if (expected_sched_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_sched_q.size()));
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
